// ===== rtl/prq_pkg.sv =====
package prq_pkg;

    // field widths of the stream words
    localparam int TASK_W      = 6;
    localparam int LEVEL_W     = 5;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

    // defaults for the top level parameters
    localparam int DEF_TASKS  = 64;
    localparam int DEF_LEVELS = 32;

    // operation codes carried in s_axis_tuser
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef logic [TASK_W-1:0]  t_task;
    typedef logic [LEVEL_W-1:0] t_level;

    // priority encoder result
    typedef struct packed {
        logic   found;
        t_level idx;
    } t_penc;

endpackage

// ===== rtl/prq_ram.sv =====
module prq_ram
    import prq_pkg::*;
#(
    parameter int WIDTH = TASK_W,
    parameter int DEPTH = DEF_TASKS
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/prq_penc.sv =====
module prq_penc
    import prq_pkg::*;
#(
    parameter int LEVELS = DEF_LEVELS
) (
    input  logic [LEVELS-1:0] i_mask,
    output t_penc             o_top
);

    // highest set bit wins, scanning upward so later lanes override
    always_comb begin
        o_top = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (i_mask[i]) begin
                o_top.found = 1'b1;
                o_top.idx   = LEVEL_W'(i);
            end
        end
    end

endmodule

// ===== rtl/bitmap_priority_ready_queue_top.sv =====
// Ready queue for a task scheduler: one FIFO of task ids per priority level.
// Input channel s_axis: tuser carries the operation (enqueue or dequeue),
// tdata the task id and the level. An enqueue appends the task at the tail
// of its level and gives no output word; a dequeue pops the head of the
// highest non-empty level and gives one output word on m_axis with the task
// id and a none_ready flag (set, with task id zero, when all levels are empty).
// Heads and tails live in one memory indexed by level, the next links in a
// second memory indexed by task; both have a registered read.
// An enqueue reads head/tail, then writes back head/tail and link.
// A dequeue reads head/tail and finishes there when the level empties or
// nothing is ready; else it then reads the link of the popped head, which
// waits for the head to arrive from memory. One item is in work at a time.
// Results go to an output register, so the next item is accepted while a
// result still waits; a dequeue that finishes while the output register is
// still full waits in a hold state until the receiver takes the old word.
// Reset (synchronous, active low) empties the ready mask and the output;
// memory contents are not cleared and need no clearing pass.
module bitmap_priority_ready_queue_top
    import prq_pkg::*;
#(
    parameter int TASKS  = DEF_TASKS,
    parameter int LEVELS = DEF_LEVELS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [5:0] task_id, [10:6] level, [15:11] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] op
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [5:0] chosen_task, [7:6] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] none_ready
    output logic                   m_axis_tuser
);

    localparam int LVL_AW  = $clog2(LEVELS);
    localparam int TASK_AW = $clog2(TASKS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_LINK = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [LEVELS-1:0] r_mask, n_mask;
    logic              r_op, n_op;
    logic              r_go, n_go;
    t_task             r_tid, n_tid;
    logic [LVL_AW-1:0] r_lvl, n_lvl;
    t_task             r_head, n_head;
    t_task             r_tail, n_tail;
    t_task             r_res_task, n_res_task;
    logic              r_res_none, n_res_none;
    logic              r_out_valid, n_out_valid;
    t_task             r_out_task, n_out_task;
    logic              r_out_none, n_out_none;

    logic              in_op;
    t_task             in_tid;
    t_level            in_level;
    logic              s_accept;
    logic              slot_free;
    t_penc             top;
    logic [LVL_AW-1:0] acc_lvl;

    logic              ht_we;
    logic [LVL_AW-1:0] ht_raddr;
    logic [2*TASK_W-1:0] ht_wdata, ht_rdata;
    t_task             ht_head, ht_tail;

    logic               lk_we;
    logic [TASK_AW-1:0] lk_waddr, lk_raddr;
    t_task              lk_wdata, lk_rdata;

    logic  res_done;
    t_task res_task;
    logic  res_none;

    // input word unpacking
    assign in_op    = s_axis_tuser;
    assign in_tid   = s_axis_tdata[TASK_W-1:0];
    assign in_level = s_axis_tdata[TASK_W+LEVEL_W-1:TASK_W];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !r_out_valid || m_axis_tready;

    // highest non-empty level
    prq_penc #(.LEVELS(LEVELS)) u_penc (
        .i_mask (r_mask),
        .o_top  (top)
    );

    assign acc_lvl  = (in_op == OP_DEQ) ? LVL_AW'(top.idx) : LVL_AW'(in_level);
    assign ht_raddr = (r_state == ST_IDLE) ? acc_lvl : r_lvl;

    // head in the low half, tail in the high half
    prq_ram #(.WIDTH(2*TASK_W), .DEPTH(LEVELS)) u_ht_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ht_we),
        .i_wr_addr (r_lvl),
        .i_wr_data (ht_wdata),
        .i_rd_addr (ht_raddr),
        .o_rd_data (ht_rdata)
    );

    assign ht_head  = ht_rdata[TASK_W-1:0];
    assign ht_tail  = ht_rdata[2*TASK_W-1:TASK_W];
    assign lk_raddr = TASK_AW'(ht_head);

    prq_ram #(.WIDTH(TASK_W), .DEPTH(TASKS)) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (lk_we),
        .i_wr_addr (lk_waddr),
        .i_wr_data (lk_wdata),
        .i_rd_addr (lk_raddr),
        .o_rd_data (lk_rdata)
    );

    // sequencer: read, modify, write back
    always_comb begin
        n_state    = r_state;
        n_mask     = r_mask;
        n_op       = r_op;
        n_go       = r_go;
        n_tid      = r_tid;
        n_lvl      = r_lvl;
        n_head     = r_head;
        n_tail     = r_tail;
        n_res_task = r_res_task;
        n_res_none = r_res_none;
        ht_we      = 1'b0;
        ht_wdata   = {r_tid, r_tid};
        lk_we      = 1'b0;
        lk_waddr   = TASK_AW'(ht_tail);
        lk_wdata   = r_tid;
        res_done   = 1'b0;
        res_task   = '0;
        res_none   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_op  = in_op;
                    n_tid = in_tid;
                    n_lvl = acc_lvl;
                    if (in_op == OP_DEQ) begin
                        n_go = top.found;
                    end else begin
                        n_go = (32'(in_level) < 32'(LEVELS)) &&
                               (32'(in_tid) < 32'(TASKS));
                    end
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (r_op == OP_ENQ) begin
                    // append at the tail, or start a new list
                    if (r_go) begin
                        ht_we = 1'b1;
                        if (r_mask[r_lvl]) begin
                            ht_wdata = {r_tid, ht_head};
                            lk_we    = (32'(ht_tail) < 32'(TASKS));
                        end else begin
                            ht_wdata = {r_tid, r_tid};
                        end
                        n_mask[r_lvl] = 1'b1;
                    end
                    n_state = ST_IDLE;
                end else if (!r_go) begin
                    res_done = 1'b1;
                    res_none = 1'b1;
                end else if (ht_head == ht_tail) begin
                    // last task of the level
                    n_mask[r_lvl] = 1'b0;
                    res_done      = 1'b1;
                    res_task      = ht_head;
                end else begin
                    n_head  = ht_head;
                    n_tail  = ht_tail;
                    n_state = ST_LINK;
                end
            end
            ST_LINK: begin
                // advance the head to its successor
                ht_we = 1'b1;
                if (32'(r_head) < 32'(TASKS)) begin
                    ht_wdata = {r_tail, lk_rdata};
                end else begin
                    ht_wdata = {r_tail, t_task'(0)};
                end
                res_done = 1'b1;
                res_task = r_head;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // park the result when the output register is still full
        if (res_done) begin
            if (slot_free) begin
                n_state = ST_IDLE;
            end else begin
                n_res_task = res_task;
                n_res_none = res_none;
                n_state    = ST_EMIT;
            end
        end
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_task  = r_out_task;
        n_out_none  = r_out_none;
        if (res_done && slot_free) begin
            n_out_valid = 1'b1;
            n_out_task  = res_task;
            n_out_none  = res_none;
        end else if ((r_state == ST_EMIT) && slot_free) begin
            n_out_valid = 1'b1;
            n_out_task  = r_res_task;
            n_out_none  = r_res_none;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mask      <= n_mask;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_go       <= n_go;
        r_tid      <= n_tid;
        r_lvl      <= n_lvl;
        r_head     <= n_head;
        r_tail     <= n_tail;
        r_res_task <= n_res_task;
        r_res_none <= n_res_none;
        r_out_task <= n_out_task;
        r_out_none <= n_out_none;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W-TASK_W)'(0), r_out_task};
    assign m_axis_tuser  = r_out_none;

endmodule

// ===== rtl/prq_checker.sv =====
module prq_checker
    import prq_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   i_s_tready,
    input logic                   i_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] i_m_tdata,
    input logic                   i_m_tuser
);

    // a word marked none_ready carries task zero
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && i_m_tuser) |-> (i_m_tdata[TASK_W-1:0] == '0))
        else $error("none_ready word with nonzero task");

    // padding bits of the output word stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tdata[OUT_TDATA_W-1:TASK_W] == '0))
        else $error("output padding not zero");

    // one item in work at a time: no accept right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && i_s_tready) |=> !i_s_tready)
        else $error("input accepted on consecutive cycles");

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=>
            (i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser)))
        else $error("stalled output word changed");

endmodule

bind bitmap_priority_ready_queue_top prq_checker u_prq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);
